// ===== rtl/tsi_pkg.sv =====
package tsi_pkg;

    localparam int CITIES   = 1024;
    localparam int IDX_W    = 10;
    localparam int CRD_W    = 18;
    localparam int LEN_W    = 48;
    localparam int DIST_W   = 19;
    localparam int SQ_W     = 38;
    localparam int SUM_W    = 22;

    typedef enum logic [1:0] {
        OP_LOAD_CITY = 2'd0,
        OP_LOAD_TOUR = 2'd1,
        OP_SET_LEN   = 2'd2,
        OP_TRY_SWAP  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOUR_ADDR,
        S_TOUR_WAIT,
        S_CITY_ADDR,
        S_CITY_WAIT,
        S_DIST,
        S_DIST_WAIT,
        S_DECIDE,
        S_WRITE_A,
        S_WRITE_B,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic [CRD_W-1:0] x_coord;
        logic [CRD_W-1:0] y_coord;
        logic [IDX_W-1:0] city_number;
        logic [LEN_W-1:0] length_value;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] tour_length;
        logic             swapped;
        logic             status;
    } t_out_item;

endpackage

// ===== rtl/tsi_if.sv =====
interface tsi_in_if;
    logic               valid;
    logic               ready;
    tsi_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tsi_out_if;
    logic               valid;
    logic               ready;
    tsi_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tsi_ram.sv =====
module tsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/tsi_dist.sv =====
module tsi_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsi_pkg::CRD_W-1:0]   i_dx,
    input  logic [tsi_pkg::CRD_W-1:0]   i_dy,
    output logic                        o_done,
    output logic [tsi_pkg::DIST_W-1:0]  o_dist
);
    import tsi_pkg::*;

    // bit-serial square of dx and dy, then binary digit-by-digit root
    localparam int CNT_W = 6;

    logic             r_phase, n_phase;
    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CRD_W-1:0] r_mx, n_mx;
    logic [CRD_W-1:0] r_my, n_my;
    logic [SQ_W:0]    r_acc, n_acc;
    logic [SQ_W:0]    r_ax, n_ax;
    logic [SQ_W:0]    r_ay, n_ay;
    logic [SQ_W+1:0]  r_rem, n_rem;
    logic [DIST_W-1:0] r_root, n_root;
    logic             r_done, n_done;
    logic [SQ_W+1:0]  w_trial;
    logic [SQ_W+1:0]  w_rsh;

    always_comb begin
        w_rsh   = {r_rem[SQ_W-1:0], r_acc[SQ_W-1:SQ_W-2]};
        w_trial = {{(SQ_W+2-DIST_W-2){1'b0}}, r_root, 2'b01};
    end

    always_comb begin
        n_phase = r_phase;
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_mx    = r_mx;
        n_my    = r_my;
        n_acc   = r_acc;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_rem   = r_rem;
        n_root  = r_root;
        n_done  = 1'b0;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = '0;
            n_mx    = i_dx;
            n_my    = i_dy;
            n_ax    = {{(SQ_W+1-CRD_W){1'b0}}, i_dx};
            n_ay    = {{(SQ_W+1-CRD_W){1'b0}}, i_dy};
            n_acc   = '0;
        end else if (r_busy && !r_phase) begin
            // one multiplier bit a cycle for each square
            n_acc = r_acc + (r_mx[0] ? r_ax : '0) + (r_my[0] ? r_ay : '0);
            n_mx  = r_mx >> 1;
            n_my  = r_my >> 1;
            n_ax  = r_ax << 1;
            n_ay  = r_ay << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(CRD_W-1)) begin
                n_phase = 1'b1;
                n_cnt   = '0;
                n_rem   = '0;
                n_root  = '0;
            end
        end else if (r_busy) begin
            // one root bit a cycle, two radicand bits shifted in
            n_acc = {r_acc[SQ_W-2:0], 2'b00};
            if (w_rsh >= w_trial) begin
                n_rem  = w_rsh - w_trial;
                n_root = {r_root[DIST_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rsh;
                n_root = {r_root[DIST_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIST_W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_acc  <= n_acc;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_dist = r_root;
endmodule

// ===== rtl/tour_swap_improver.sv =====
// channel | dir | payload                                    | accepted when
// i_req   | in  | opcode, indexes, coords, city, length      | valid && ready
// o_rsp   | out | tour_length, swapped, status               | valid && ready
//
// loads and length sets: response the cycle after acceptance
// rejected swaps: decide, response, idle
// a swap attempt: decide, old then new edge terms (adjacency skips shared ones), then the
// length update, response and idle, with the two tour writes when committed; per edge a
// tour read for each endpoint, a city read for each, a start and a wait in the shared
// distance unit (square bits first, then root bits, then done)
// one request at a time; the response register holds until taken, stalls add cycles
// reset is synchronous active low and clears control and the length register
module tour_swap_improver (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tsi_in_if.sink  i_req,
    tsi_out_if.source o_rsp
);
    import tsi_pkg::*;

    localparam int NE = 8;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_a, r_b, r_bn;
    logic             r_apart;
    logic [2:0]       r_edge, n_edge;
    logic             r_end, n_end;          // which endpoint of the edge
    logic [IDX_W-1:0] r_ca, r_cb;            // tour city of each endpoint
    logic [CRD_W-1:0] r_xa, r_ya, r_xb, r_yb;
    logic [SUM_W-1:0] r_old, r_new, n_old, n_new;
    logic             r_swapped, r_status;
    logic             r_ovalid;
    logic [IDX_W-1:0] r_ta;                  // city at A for swap write

    // memories
    logic             w_tour_we, w_city_we;
    logic [IDX_W-1:0] w_tour_wa, w_tour_wd, w_tour_ra, w_tour_rd;
    logic [IDX_W-1:0] w_city_wa, w_city_ra;
    logic [2*CRD_W-1:0] w_city_wd, w_city_rd;

    tsi_ram #(.WIDTH(2*CRD_W), .DEPTH(CITIES)) u_city (
        .i_clk(i_clk), .i_we(w_city_we), .i_waddr(w_city_wa), .i_wdata(w_city_wd),
        .i_raddr(w_city_ra), .o_rdata(w_city_rd)
    );

    // distance unit
    logic             w_dstart, w_ddone;
    logic [CRD_W-1:0] w_dx, w_dy;
    logic [DIST_W-1:0] w_dist;

    tsi_dist u_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dx(w_dx), .i_dy(w_dy), .o_done(w_ddone), .o_dist(w_dist)
    );

    assign w_dx = (r_xa > r_xb) ? r_xa - r_xb : r_xb - r_xa;
    assign w_dy = (r_ya > r_yb) ? r_ya - r_yb : r_yb - r_ya;

    // edge table: edges 0..3 old, 4..7 new; 2,3,6,7 only when apart
    logic [IDX_W-1:0] w_pos;
    always_comb begin
        w_pos = r_a;
        unique case ({r_edge, r_end})
            4'd0:  w_pos = r_a - 1'b1;
            4'd1:  w_pos = r_a;
            4'd2:  w_pos = r_b;
            4'd3:  w_pos = r_bn;
            4'd4:  w_pos = r_a;
            4'd5:  w_pos = r_a + 1'b1;
            4'd6:  w_pos = r_b - 1'b1;
            4'd7:  w_pos = r_b;
            4'd8:  w_pos = r_a - 1'b1;
            4'd9:  w_pos = r_b;
            4'd10: w_pos = r_a;
            4'd11: w_pos = r_bn;
            4'd12: w_pos = r_b;
            4'd13: w_pos = r_a + 1'b1;
            4'd14: w_pos = r_b - 1'b1;
            4'd15: w_pos = r_a;
            default: w_pos = r_a;
        endcase
    end

    logic w_req_fire, w_rsp_fire;
    assign w_req_fire = i_req.valid && i_req.ready;
    assign w_rsp_fire = o_rsp.valid && o_rsp.ready;

    // loads happen on acceptance; swap's second write uses the B slot
    logic             w_ld_tour, w_ld_city;
    assign w_ld_tour = r_state == S_IDLE && w_req_fire
                       && i_req.payload.opcode == OP_LOAD_TOUR;
    assign w_ld_city = r_state == S_IDLE && w_req_fire
                       && i_req.payload.opcode == OP_LOAD_CITY;

    // swap operand ordering
    logic [IDX_W-1:0] w_lo, w_hi;
    logic             w_bad;
    assign w_lo  = (r_item.first_index < r_item.second_index) ? r_item.first_index
                                                               : r_item.second_index;
    assign w_hi  = (r_item.first_index < r_item.second_index) ? r_item.second_index
                                                               : r_item.first_index;
    assign w_bad = (w_lo == w_hi) || (w_lo == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_req_fire) begin
                             n_state = (i_req.payload.opcode == OP_TRY_SWAP) ? S_DECIDE
                                                                             : S_RESP;
                         end
            S_TOUR_ADDR: n_state = S_TOUR_WAIT;
            S_TOUR_WAIT: n_state = r_end ? S_CITY_ADDR : S_TOUR_ADDR;
            S_CITY_ADDR: n_state = S_CITY_WAIT;
            S_CITY_WAIT: n_state = r_end ? S_DIST : S_CITY_ADDR;
            S_DIST:      n_state = S_DIST_WAIT;
            S_DIST_WAIT: if (w_ddone) begin
                             if (r_edge == 3'(NE-1) || (!r_apart && r_edge == 3'd5)) begin
                                 n_state = S_WRITE_A;
                             end else begin
                                 n_state = S_TOUR_ADDR;
                             end
                         end
            S_DECIDE:    n_state = w_bad ? S_RESP : S_TOUR_ADDR;
            S_WRITE_A:   n_state = (r_new < r_old) ? S_WRITE_B : S_RESP;
            S_WRITE_B:   n_state = S_RESP;
            S_RESP:      if (w_rsp_fire) begin
                             n_state = S_IDLE;
                         end
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    logic [SUM_W-1:0] w_gain;
    assign w_gain = r_old - r_new;

    always_comb begin
        w_tour_we = 1'b0;
        w_tour_wa = r_item.first_index;
        w_tour_wd = r_item.city_number;
        w_tour_ra = w_pos;
        w_city_we = w_ld_city;
        w_city_wa = i_req.payload.first_index;
        w_city_wd = {i_req.payload.x_coord, i_req.payload.y_coord};
        w_city_ra = r_end ? r_cb : r_ca;
        w_dstart  = 1'b0;
        n_edge    = r_edge;
        n_end     = r_end;
        n_old     = r_old;
        n_new     = r_new;
        n_len     = r_len;
        unique case (r_state)
            S_IDLE: begin
                n_edge = '0;
                n_end  = 1'b0;
                n_old  = '0;
                n_new  = '0;
                if (w_req_fire && i_req.payload.opcode == OP_SET_LEN) begin
                    n_len = i_req.payload.length_value;
                end
            end
            S_TOUR_WAIT: n_end = !r_end;
            S_CITY_WAIT: n_end = !r_end;
            S_DIST:      w_dstart = 1'b1;
            S_DIST_WAIT: begin
                // park the tour read on A so its city is at hand for the swap
                w_tour_ra = r_a;
                if (w_ddone) begin
                    if (r_edge[2]) begin
                        n_new = r_new + SUM_W'(w_dist);
                    end else begin
                        n_old = r_old + SUM_W'(w_dist);
                    end
                    // adjacent pair skips the shared-edge terms
                    n_edge = (!r_apart && r_edge == 3'd1) ? 3'd4 : r_edge + 1'b1;
                end
            end
            S_DECIDE: begin
                w_tour_ra = w_lo;
            end
            S_WRITE_A: begin
                w_tour_ra = r_b;
                if (r_new < r_old) begin
                    n_len = (r_len > LEN_W'(w_gain)) ? r_len - LEN_W'(w_gain) : '0;
                end
            end
            S_WRITE_B: begin
                w_tour_we = 1'b1;
                w_tour_wa = r_a;
                w_tour_wd = w_tour_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_ovalid  <= 1'b0;
            r_swapped <= 1'b0;
            r_status  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (r_state == S_IDLE && w_req_fire) begin
                r_swapped <= 1'b0;
                r_status  <= 1'b0;
                if (i_req.payload.opcode != OP_TRY_SWAP) begin
                    r_ovalid <= 1'b1;
                end
            end
            if (r_state == S_DECIDE && w_bad) begin
                r_status <= 1'b1;
                r_ovalid <= 1'b1;
            end
            if (r_state == S_WRITE_A) begin
                r_swapped <= (r_new < r_old);
                r_ovalid  <= 1'b1;
            end
            if (w_rsp_fire) begin
                r_ovalid <= 1'b0;
            end
        end
        if (r_state == S_IDLE && w_req_fire) begin
            r_item <= i_req.payload;
        end
        if (r_state == S_DECIDE) begin
            r_a     <= w_lo;
            r_b     <= w_hi;
            r_bn    <= w_hi + 1'b1;
            r_apart <= (w_hi - w_lo) != IDX_W'(1);
        end
        if (r_state == S_TOUR_WAIT) begin
            if (r_end) r_cb <= w_tour_rd;
            else       r_ca <= w_tour_rd;
        end
        if (r_state == S_CITY_WAIT) begin
            if (r_end) {r_xb, r_yb} <= w_city_rd;
            else       {r_xa, r_ya} <= w_city_rd;
        end
        if (r_state == S_WRITE_A) begin
            r_ta <= w_tour_rd;
        end
        r_edge <= n_edge;
        r_end  <= n_end;
        r_old  <= n_old;
        r_new  <= n_new;
    end

    logic             r_wb_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= (r_state == S_WRITE_B);
        end
    end

    // final memory write muxing
    logic             m_tour_we;
    logic [IDX_W-1:0] m_tour_wa, m_tour_wd;
    always_comb begin
        m_tour_we = w_tour_we;
        m_tour_wa = w_tour_wa;
        m_tour_wd = w_tour_wd;
        priority if (w_ld_tour) begin
            m_tour_we = 1'b1;
            m_tour_wa = i_req.payload.first_index;
            m_tour_wd = i_req.payload.city_number;
        end else if (r_wb_pend) begin
            m_tour_we = 1'b1;
            m_tour_wa = r_b;
            m_tour_wd = r_ta;
        end
    end

    tsi_ram #(.WIDTH(IDX_W), .DEPTH(CITIES)) u_tour (
        .i_clk(i_clk), .i_we(m_tour_we), .i_waddr(m_tour_wa), .i_wdata(m_tour_wd),
        .i_raddr(w_tour_ra), .o_rdata(w_tour_rd)
    );

    assign i_req.ready = (r_state == S_IDLE) && !r_wb_pend;
    assign o_rsp.valid = r_ovalid && (r_state == S_RESP);
    assign o_rsp.payload.tour_length = r_len;
    assign o_rsp.payload.swapped     = r_swapped;
    assign o_rsp.payload.status      = r_status;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_fire |=> !o_rsp.valid) else $error("response repeated");
    a_no_swap_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.payload.swapped && o_rsp.payload.status))
        else $error("swap with reject status");
    a_len_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE_A) |=> r_len <= $past(r_len)) else $error("length grew");
`endif
endmodule
